// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the rtl, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define UPI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("upi assertion failed");

// condition must never be seen outside reset
`define UPI_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("upi forbidden condition seen");

`else

`define UPI_ASSERT(label, clk, rst, prop)
`define UPI_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- sv/upi_pkg.sv -----
// ---------------------------------------------------------------------------
// upi_pkg
// types, constants and tables of the parking indicator
// ---------------------------------------------------------------------------
package upi_pkg;

  localparam int TIME_BITS_DEF = 48;

  // event codes
  typedef enum logic [1:0] {
    OP_ECHO_RISE = 2'd0,
    OP_ECHO_FALL = 2'd1,
    OP_UPDATE    = 2'd2,
    OP_BLINK     = 2'd3
  } opcode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SYSTEM_ENABLE = 2'd0,
    REG_BLINK_ENABLE  = 2'd1,
    REG_FRESH_TIMEOUT = 2'd2,
    REG_OCC_THRESHOLD = 2'd3
  } reg_idx_t;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam int DIST_BITS    = 9;
  localparam int TIMEOUT_BITS = 24;
  localparam int PERIOD_BITS  = 6;
  localparam int COUNT_BITS   = 5;

  typedef logic [DIST_BITS-1:0]           dist_t;
  typedef logic signed [PERIOD_BITS-1:0]  period_t;

  typedef struct packed {
    logic                    system_enable;
    logic                    blink_enable;
    logic [TIMEOUT_BITS-1:0] fresh_timeout_us;
    dist_t                   occupied_threshold_cm;
  } cfg_t;

  localparam logic                    SYSTEM_ENABLE_RST = 1'b1;
  localparam logic                    BLINK_ENABLE_RST  = 1'b1;
  localparam logic [TIMEOUT_BITS-1:0] FRESH_TIMEOUT_RST = 24'd200000;
  localparam dist_t                   OCC_THRESHOLD_RST = 9'd200;

  // echo width to centimetres
  localparam int CM_DIVISOR  = 58;
  localparam int DIST_LIMIT  = 450;
  localparam int WIDTH_LIMIT = DIST_LIMIT * CM_DIVISOR;
  localparam int WIDTH_BITS  = $clog2(WIDTH_LIMIT);
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam int RECIP_BITS  = $clog2(RECIP + 1);

  localparam dist_t FAR_DISTANCE = 9'd400;

  localparam period_t PERIOD_OFF   = -6'sd1;
  localparam period_t PERIOD_SOLID = 6'sd0;
  localparam int      MAX_PERIOD   = 20;

  localparam int TABLE_LEN = 7;
  localparam dist_t DIST_TAB [TABLE_LEN] = '{
    9'd10, 9'd30, 9'd60, 9'd100, 9'd150, 9'd200, 9'd250
  };
  localparam period_t PERIOD_TAB [TABLE_LEN] = '{
    6'sd0, 6'sd2, 6'sd5, 6'sd8, 6'sd14, 6'sd20, -6'sd1
  };

endpackage

// ----- sv/upi_evt_if.sv -----
// ---------------------------------------------------------------------------
// upi_evt_if
// event channel: opcode and timestamp with valid/ready
// ---------------------------------------------------------------------------
interface upi_evt_if
  import upi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();

  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [TIME_BITS-1:0] time_us;

  modport source (output valid, output opcode, output time_us, input ready);
  modport sink   (input valid, input opcode, input time_us, output ready);

endinterface

// ----- sv/upi_res_if.sv -----
// ---------------------------------------------------------------------------
// upi_res_if
// result channel: led levels, distance, occupancy and blink period
// ---------------------------------------------------------------------------
interface upi_res_if
  import upi_pkg::*;
();

  logic    valid;
  logic    ready;
  logic    status_led;
  logic    blink_led;
  dist_t   range_cm;
  logic    occupied;
  period_t blink_period;

  modport source (
    output valid, output status_led, output blink_led, output range_cm,
    output occupied, output blink_period, input ready
  );
  modport sink (
    input valid, input status_led, input blink_led, input range_cm,
    input occupied, input blink_period, output ready
  );

endinterface

// ----- sv/upi_apb_regs.sv -----
// ---------------------------------------------------------------------------
// upi_apb_regs
// apb configuration registers with read-back
// ---------------------------------------------------------------------------
module upi_apb_regs
  import upi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.system_enable         <= SYSTEM_ENABLE_RST;
      cfg.blink_enable          <= BLINK_ENABLE_RST;
      cfg.fresh_timeout_us      <= FRESH_TIMEOUT_RST;
      cfg.occupied_threshold_cm <= OCC_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SYSTEM_ENABLE: cfg.system_enable         <= pwdata[0];
        REG_BLINK_ENABLE:  cfg.blink_enable          <= pwdata[0];
        REG_FRESH_TIMEOUT: cfg.fresh_timeout_us      <= pwdata[TIMEOUT_BITS-1:0];
        REG_OCC_THRESHOLD: cfg.occupied_threshold_cm <= pwdata[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SYSTEM_ENABLE: prdata[0]                = cfg.system_enable;
      REG_BLINK_ENABLE:  prdata[0]                = cfg.blink_enable;
      REG_FRESH_TIMEOUT: prdata[TIMEOUT_BITS-1:0] = cfg.fresh_timeout_us;
      REG_OCC_THRESHOLD: prdata[DIST_BITS-1:0]    = cfg.occupied_threshold_cm;
      default: ;
    endcase
  end

endmodule

// ----- sv/upi_echo_conv.sv -----
// ---------------------------------------------------------------------------
// upi_echo_conv
// echo pulse width to centimetres with range check
// ---------------------------------------------------------------------------
module upi_echo_conv
  import upi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] start,
  output dist_t                cm,
  output logic                 dist_ok
);

  logic [TIME_BITS-1:0]             width;
  logic [WIDTH_BITS+RECIP_BITS-1:0] prod;

  // wraps modulo the timebase
  assign width = now - start;

  // only widths that give 1..449 cm matter, they fit in WIDTH_BITS
  assign dist_ok = (width >= TIME_BITS'(CM_DIVISOR)) && (width < TIME_BITS'(WIDTH_LIMIT));

  // divide by reciprocal, exact over the accepted width range
  assign prod = (WIDTH_BITS+RECIP_BITS)'(width[WIDTH_BITS-1:0])
              * (WIDTH_BITS+RECIP_BITS)'(RECIP);
  assign cm = prod[RECIP_SHIFT +: DIST_BITS];

endmodule

// ----- sv/upi_near_period.sv -----
// ---------------------------------------------------------------------------
// upi_near_period
// blink period of the nearest table distance, ties to the earlier entry
// ---------------------------------------------------------------------------
module upi_near_period
  import upi_pkg::*;
(
  input  dist_t   cm,
  output period_t period
);

  // at or below the midpoint of two neighbours the lower one is taken
  always_comb begin
    period = PERIOD_TAB[TABLE_LEN-1];
    for (int i = TABLE_LEN - 2; i >= 0; i--) begin
      if ({1'b0, cm} <= (({1'b0, DIST_TAB[i]} + {1'b0, DIST_TAB[i+1]}) >> 1)) begin
        period = PERIOD_TAB[i];
      end
    end
  end

endmodule

// ----- sv/ultrasonic_parking_indicator.sv -----
// ---------------------------------------------------------------------------
// ultrasonic_parking_indicator
// an accepted event passes the input register, then the state register, which is the result
// throughput: one event per cycle while results are taken, a stalled result
//   holds one event in the input register and then stalls the input
// reset: synchronous, clears state to 400 cm, free, period off, leds dark,
//   configuration to enabled, 200000 us timeout, 200 cm threshold
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_parking_indicator
  import upi_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  upi_evt_if.sink                  evt,
  upi_res_if.source                res
);

  cfg_t cfg;

  // input register
  logic                 in_valid;
  opcode_t              in_op;
  logic [TIME_BITS-1:0] in_time;

  // block state, also the result payload
  logic [TIME_BITS-1:0] echo_start_time;
  logic [TIME_BITS-1:0] last_valid_time;
  dist_t                sensor_distance;
  dist_t                shown_distance;
  logic                 occupied_flag;
  period_t              period_reg;
  logic [COUNT_BITS-1:0] blink_count;
  logic                 blink_level;
  logic                 status_level;
  logic                 res_valid;

  logic                  step;
  logic                  evt_take;
  dist_t                 echo_dist;
  logic                  echo_ok;
  period_t               near_period;
  logic [TIME_BITS-1:0]  age;
  logic                  stale;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  count_wrap;

  upi_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  upi_echo_conv #(.TIME_BITS(TIME_BITS)) u_conv (
    .now     (in_time),
    .start   (echo_start_time),
    .cm      (echo_dist),
    .dist_ok (echo_ok)
  );

  upi_near_period u_near (
    .cm     (sensor_distance),
    .period (near_period)
  );

  // handshake: the state register doubles as the result register
  assign step     = in_valid && (!res_valid || res.ready);
  assign evt.ready = !in_valid || step;
  assign evt_take = evt.valid && evt.ready;

  assign age   = in_time - last_valid_time;
  assign stale = age >= TIME_BITS'(cfg.fresh_timeout_us);

  assign count_inc  = blink_count + 1'b1;
  assign count_wrap = {1'b0, count_inc} >= PERIOD_BITS'(period_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt_take) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      in_op   <= opcode_t'(evt.opcode);
      in_time <= evt.time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_start_time <= '0;
      last_valid_time <= '0;
      sensor_distance <= FAR_DISTANCE;
      shown_distance  <= FAR_DISTANCE;
      occupied_flag   <= 1'b0;
      period_reg      <= PERIOD_OFF;
      blink_count     <= '0;
      blink_level     <= 1'b0;
      status_level    <= 1'b0;
    end else if (step) begin
      unique case (in_op)
        OP_ECHO_RISE: begin
          echo_start_time <= in_time;
        end
        OP_ECHO_FALL: begin
          if (echo_ok) begin
            sensor_distance <= echo_dist;
            last_valid_time <= in_time;
          end
        end
        OP_UPDATE: begin
          if (!cfg.system_enable) begin
            occupied_flag <= 1'b0;
            period_reg    <= PERIOD_OFF;
            status_level  <= 1'b0;
          end else if (stale) begin
            shown_distance <= FAR_DISTANCE;
            occupied_flag  <= 1'b0;
            period_reg     <= PERIOD_OFF;
            status_level   <= 1'b1;
          end else begin
            shown_distance <= sensor_distance;
            occupied_flag  <= sensor_distance < cfg.occupied_threshold_cm;
            period_reg     <= near_period;
            status_level   <= !(sensor_distance < cfg.occupied_threshold_cm);
          end
        end
        OP_BLINK: begin
          priority if (!cfg.system_enable || !cfg.blink_enable || period_reg == PERIOD_OFF) begin
            blink_level <= 1'b0;
            blink_count <= '0;
          end else if (period_reg == PERIOD_SOLID) begin
            // held on, counter frozen
            blink_level <= 1'b1;
          end else if (count_wrap) begin
            blink_level <= !blink_level;
            blink_count <= '0;
          end else begin
            blink_count <= count_inc;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.valid        = res_valid;
  assign res.status_led   = status_level;
  assign res.blink_led    = blink_level;
  assign res.range_cm     = shown_distance;
  assign res.occupied     = occupied_flag;
  assign res.blink_period = period_reg;

  `UPI_ASSERT(a_step_gives_result, clk, rst, step |=> res_valid)
  `UPI_ASSERT(a_period_from_table, clk, rst,
    period_reg == PERIOD_TAB[0] || period_reg == PERIOD_TAB[1] ||
    period_reg == PERIOD_TAB[2] || period_reg == PERIOD_TAB[3] ||
    period_reg == PERIOD_TAB[4] || period_reg == PERIOD_TAB[5] ||
    period_reg == PERIOD_TAB[6])
  `UPI_ASSERT_NEVER(a_occupied_lit, clk, rst, occupied_flag && status_level)
  `UPI_ASSERT(a_count_bounded, clk, rst, blink_count < COUNT_BITS'(MAX_PERIOD))
  `UPI_ASSERT(a_state_held_on_stall, clk, rst,
    (res_valid && !res.ready) |=> $stable(shown_distance) && $stable(period_reg))

endmodule

// ----- tb/tb_ultrasonic_parking_indicator.sv -----
// ---------------------------------------------------------------------------
// tb_ultrasonic_parking_indicator
// self-checking bench: queued event words through a clocked driver, a local
// model of sensor, occupancy and blink state, and a clocked monitor that
// checks each result word field by field, registers rewritten while idle
// ---------------------------------------------------------------------------
module tb_ultrasonic_parking_indicator
  import upi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW          = TIME_BITS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    opcode_t        op;
    logic [TW-1:0]  stamp;
  } evt_word_t;

  typedef struct {
    logic    status_led;
    logic    blink_led;
    dist_t   range_cm;
    logic    occupied;
    period_t blink_period;
  } ind_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  upi_evt_if evt ();
  upi_res_if res ();

  ultrasonic_parking_indicator dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .evt     (evt),
    .res     (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register shadow, kept in step with every write
  cfg_t cfg = '{system_enable: SYSTEM_ENABLE_RST, blink_enable: BLINK_ENABLE_RST,
                fresh_timeout_us: FRESH_TIMEOUT_RST,
                occupied_threshold_cm: OCC_THRESHOLD_RST};

  // indicator state as the block should hold it
  logic [TW-1:0]         echo_start_t = '0;
  logic [TW-1:0]         last_valid_t = '0;
  dist_t                 sensor_cm = FAR_DISTANCE;
  dist_t                 shown_cm = FAR_DISTANCE;
  logic                  occ_q = 1'b0;
  period_t               period_q = PERIOD_OFF;
  logic [COUNT_BITS-1:0] blink_cnt = '0;
  logic                  blink_q = 1'b0;
  logic                  status_q = 1'b0;

  evt_word_t     pending_words[$];
  ind_word_t     expected_words[$];
  int            items_queued = 0;
  int            items_accepted = 0;
  int            results_checked = 0;
  int            errors = 0;
  int            settings_seen = 1;
  int            op_seen[4] = '{0, 0, 0, 0};
  int            idle_pct = 32;
  int            holds_asked = 0;
  int            holds_served = 0;
  int            hold_left = 0;
  int            cycle_count = 0;
  logic [TW-1:0] now_t = '0;

  function automatic period_t nearest_blink_period(dist_t d);
    int      best_diff;
    int      diff;
    period_t best;
    best_diff = 1 << 30;
    best = PERIOD_OFF;
    for (int i = 0; i < TABLE_LEN; i++) begin
      diff = int'(d) - int'(DIST_TAB[i]);
      if (diff < 0) diff = -diff;
      // strict compare keeps the earlier entry on a tie
      if (diff < best_diff) begin
        best_diff = diff;
        best = PERIOD_TAB[i];
      end
    end
    return best;
  endfunction

  function automatic ind_word_t predict_indicator(opcode_t op, logic [TW-1:0] t);
    logic [TW-1:0] span;
    ind_word_t     w;
    case (op)
      OP_ECHO_RISE: echo_start_t = t;
      OP_ECHO_FALL: begin
        span = (t - echo_start_t) / CM_DIVISOR;
        if (span > 0 && span < DIST_LIMIT) begin
          sensor_cm = span[DIST_BITS-1:0];
          last_valid_t = t;
        end
      end
      OP_UPDATE: begin
        span = t - last_valid_t;
        if (!cfg.system_enable) begin
          occ_q = 1'b0;
          period_q = PERIOD_OFF;
        end else if (span >= cfg.fresh_timeout_us) begin
          shown_cm = FAR_DISTANCE;
          occ_q = 1'b0;
          period_q = PERIOD_OFF;
        end else begin
          shown_cm = sensor_cm;
          occ_q = shown_cm < cfg.occupied_threshold_cm;
          period_q = nearest_blink_period(shown_cm);
        end
        status_q = cfg.system_enable && !occ_q;
      end
      OP_BLINK: begin
        if (!cfg.system_enable || !cfg.blink_enable || period_q == PERIOD_OFF) begin
          blink_q = 1'b0;
          blink_cnt = '0;
        end else if (period_q == PERIOD_SOLID) begin
          blink_q = 1'b1;
        end else begin
          blink_cnt = blink_cnt + 1'b1;
          if (period_q > 0 && int'(blink_cnt) >= int'(period_q)) begin
            blink_q = !blink_q;
            blink_cnt = '0;
          end
        end
      end
    endcase
    w.status_led = status_q;
    w.blink_led = blink_q;
    w.range_cm = shown_cm;
    w.occupied = occ_q;
    w.blink_period = period_q;
    return w;
  endfunction

  function automatic void push_evt(opcode_t op, logic [TW-1:0] stamp);
    evt_word_t w;
    w.op = op;
    w.stamp = stamp;
    pending_words.push_back(w);
    items_queued++;
  endfunction

  function automatic logic [TW-1:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TW-1:0];
  endfunction

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic wait_drained();
    while (!(items_accepted == items_queued && expected_words.size() == 0))
      @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SYSTEM_ENABLE: cfg.system_enable = value[0];
      REG_BLINK_ENABLE:  cfg.blink_enable = value[0];
      REG_FRESH_TIMEOUT: cfg.fresh_timeout_us = value[TIMEOUT_BITS-1:0];
      REG_OCC_THRESHOLD: cfg.occupied_threshold_cm = value[DIST_BITS-1:0];
    endcase
  endtask

  // mostly rise/fall pairs followed by ticks, the rest loose events
  task automatic gen_traffic(int n);
    int            target;
    int            d;
    int            k;
    logic [TW-1:0] w;
    target = items_queued + n;
    while (items_queued < target) begin
      if ($urandom_range(99) < 3) now_t = {TW{1'b1}} - TW'($urandom_range(60000));
      if ($urandom_range(99) < 70) begin
        now_t += $urandom_range(5000);
        push_evt(OP_ECHO_RISE, now_t);
        case ($urandom_range(9))
          0: w = TW'($urandom_range(CM_DIVISOR - 1));
          1: w = $urandom_range(1) ? TW'(WIDTH_LIMIT + $urandom_range(5000)) : rand_stamp();
          default: begin
            k = $urandom_range(TABLE_LEN - 2);
            case ($urandom_range(3))
              0: d = $urandom_range(DIST_LIMIT - 1, 1);
              1: d = int'(DIST_TAB[k]) + int'($urandom_range(2)) - 1;
              // at or one above the midpoint of two table entries
              2: d = (int'(DIST_TAB[k]) + int'(DIST_TAB[k + 1])) / 2 + int'($urandom_range(1));
              default: d = int'(cfg.occupied_threshold_cm) + int'($urandom_range(2)) - 1;
            endcase
            w = TW'(d * CM_DIVISOR + int'($urandom_range(CM_DIVISOR - 1)));
          end
        endcase
        now_t += w;
        push_evt(OP_ECHO_FALL, now_t);
        repeat ($urandom_range(2)) begin
          now_t += ($urandom_range(3) == 0) ? 0 : $urandom_range(260000);
          push_evt(OP_UPDATE, now_t);
        end
        repeat ($urandom_range(8)) begin
          now_t += $urandom_range(20000);
          push_evt(OP_BLINK, now_t);
        end
      end else begin
        push_evt(opcode_t'($urandom_range(3)),
                 $urandom_range(1) ? rand_stamp() : now_t + TW'($urandom_range(1000)));
      end
    end
  endtask

  task automatic run_phase(logic sys_en, logic blk_en, logic [TIMEOUT_BITS-1:0] tmo,
                           dist_t thr, int n);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_SYSTEM_ENABLE, APB_DATA_BITS'(sys_en));
    write_reg(REG_BLINK_ENABLE, APB_DATA_BITS'(blk_en));
    write_reg(REG_FRESH_TIMEOUT, APB_DATA_BITS'(tmo));
    write_reg(REG_OCC_THRESHOLD, APB_DATA_BITS'(thr));
    settings_seen++;
    gen_traffic(n);
  endtask

  // event driver
  always @(posedge clk) begin : event_driver
    evt_word_t nxt;
    if (rst) begin
      evt.valid <= 1'b0;
    end else begin
      if (evt.valid && evt.ready) begin
        expected_words.push_back(predict_indicator(opcode_t'(evt.opcode), evt.time_us));
        op_seen[evt.opcode]++;
        items_accepted++;
      end
      if (!evt.valid || evt.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_words.pop_front();
          evt.valid <= 1'b1;
          evt.opcode <= nxt.op;
          evt.time_us <= nxt.stamp;
        end else begin
          evt.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(posedge clk) begin : result_receiver
    if (rst) begin
      res.ready <= 1'b0;
      hold_left <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= HOLD_CYCLES;
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= $urandom_range(99) >= idle_pct;
    end
  end

  always @(posedge clk) begin : result_monitor
    ind_word_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, actual status %0b",
                 $time, res.status_led);
      end else begin
        want = expected_words.pop_front();
        check_field("status_led", want.status_led, res.status_led);
        check_field("blink_led", want.blink_led, res.blink_led);
        check_field("range_cm", want.range_cm, res.range_cm);
        check_field("occupied", want.occupied, res.occupied);
        check_field("blink_period", want.blink_period, res.blink_period);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_words.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    evt.valid = 1'b0;
    evt.opcode = OP_ECHO_RISE;
    evt.time_us = '0;
    res.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // update and blink straight after reset see the reset reading as fresh
    push_evt(OP_UPDATE, TW'(0));
    push_evt(OP_BLINK, TW'(10));
    // fall with no rise yet: width counts from time zero, 50 cm
    push_evt(OP_ECHO_FALL, TW'(50 * CM_DIVISOR));
    push_evt(OP_UPDATE, TW'(3000));
    repeat (5) push_evt(OP_BLINK, TW'(3100));
    // zero quotient dropped, then 450 dropped, then 449 kept
    push_evt(OP_ECHO_RISE, TW'(10000));
    push_evt(OP_ECHO_FALL, TW'(10000 + CM_DIVISOR - 1));
    push_evt(OP_ECHO_RISE, TW'(20000));
    push_evt(OP_ECHO_FALL, TW'(20000 + WIDTH_LIMIT));
    push_evt(OP_ECHO_RISE, TW'(50000));
    push_evt(OP_ECHO_FALL, TW'(50000 + 449 * CM_DIVISOR + CM_DIVISOR - 1));
    push_evt(OP_UPDATE, TW'(76100));
    // 20 cm sits halfway between two entries, the earlier one (solid) wins
    push_evt(OP_ECHO_RISE, TW'(80000));
    push_evt(OP_ECHO_FALL, TW'(80000 + 20 * CM_DIVISOR));
    push_evt(OP_UPDATE, TW'(81200));
    push_evt(OP_BLINK, TW'(81300));
    push_evt(OP_BLINK, TW'(81400));
    // age equal to the timeout counts as stale
    push_evt(OP_UPDATE, TW'(80000 + 20 * CM_DIVISOR + 200000));
    // pulse across the time wrap
    push_evt(OP_ECHO_RISE, {TW{1'b1}} - TW'(99));
    push_evt(OP_ECHO_FALL, TW'(100 * CM_DIVISOR - 100));
    push_evt(OP_UPDATE, TW'(100 * CM_DIVISOR - 100));
    push_evt(OP_UPDATE, {TW{1'b1}});
    now_t = TW'(400000);
    gen_traffic(150);

    run_phase(1'b1, 1'b1, {TIMEOUT_BITS{1'b1}}, 9'd511, 170);
    run_phase(1'b1, 1'b0, FRESH_TIMEOUT_RST, 9'd0, 170);
    run_phase(1'b0, 1'b1, 24'd100000, 9'd300, 150);
    run_phase(1'b1, 1'b1, 24'd0, OCC_THRESHOLD_RST, 150);
    run_phase(1'b1, 1'b1, 24'd1, 9'd450, 150);

    // stretch at full rate on both sides
    idle_pct = 0;
    run_phase(1'b1, 1'b1, TIMEOUT_BITS'($urandom_range(24'hFFFFFF, 1)),
              dist_t'($urandom_range(511)), 200);
    wait_drained();
    idle_pct = 32;

    // receiver holds off while the sender keeps offering
    run_phase(1'b1, 1'b1, FRESH_TIMEOUT_RST, OCC_THRESHOLD_RST, 200);
    holds_asked++;

    repeat (3) begin
      run_phase(1'(($urandom_range(3) != 0)), 1'($urandom_range(1)),
                $urandom_range(1) ? TIMEOUT_BITS'($urandom_range(300000))
                                  : TIMEOUT_BITS'($urandom_range(24'hFFFFFF)),
                dist_t'($urandom_range(511)), 150);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("checked %0d result words from %0d events over %0d register settings",
             results_checked, items_accepted, settings_seen);
    $display("events by kind: rise %0d, fall %0d, update %0d, blink %0d",
             op_seen[OP_ECHO_RISE], op_seen[OP_ECHO_FALL], op_seen[OP_UPDATE],
             op_seen[OP_BLINK]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
